>>> hw/rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types, code constants and code tables of the raster row compressor.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int unsigned MaxRowBytesDef = 2048;
  localparam int unsigned FifoDepthDef   = 4;

  localparam int CodeW  = 15;  // widest single command: opening plus rest code
  localparam int WidthW = 5;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_STRIPE = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_CODE  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // One packer command; eoi marks the last command of an input item.
  typedef struct packed {
    op_e               op;
    logic [CodeW-1:0]  code;
    logic [WidthW-1:0] width;
    logic              eoi;
  } cmd_t;

  localparam logic [10:0]       RestCode  = 11'h007;
  localparam logic [WidthW-1:0] RestWidth = 5'd11;
  localparam logic [3:0]        EscCode   = 4'h7;
  localparam logic [WidthW-1:0] EscWidth  = 5'd4;
  localparam logic [6:0]        ChunkMax  = 7'd127;
  localparam logic [WidthW-1:0] ChunkW    = 5'd7;
  localparam logic [1:0]        HitTag    = 2'h0;
  localparam logic [1:0]        MissTag   = 2'h2;
  localparam logic [WidthW-1:0] HitWidth  = 5'd6;
  localparam logic [WidthW-1:0] MissWidth = 5'd10;
  localparam logic [7:0]        InvMask   = 8'hff;

  // Short count codes for run lengths 1..7.
  function automatic logic [5:0] cnt_code(input logic [2:0] len);
    logic [5:0] c;
    case (len)
      3'd3:    c = 6'h03;
      3'd4:    c = 6'h0b;
      3'd5:    c = 6'h0f;
      3'd6:    c = 6'h1f;
      3'd7:    c = 6'h3f;
      3'd2:    c = 6'h01;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

  function automatic logic [WidthW-1:0] cnt_width(input logic [2:0] len);
    logic [WidthW-1:0] w;
    case (len)
      3'd1:    w = 5'd1;
      3'd2:    w = 5'd2;
      3'd3:    w = 5'd4;
      3'd4:    w = 5'd4;
      3'd5:    w = 5'd5;
      3'd6:    w = 5'd6;
      3'd7:    w = 5'd6;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

  // Copy-left opening codes for distances 1..3.
  function automatic logic [3:0] open_code(input logic [1:0] distance);
    logic [3:0] c;
    case (distance)
      2'd2:    c = 4'h7;
      2'd3:    c = 4'hf;
      default: c = 4'h3;
    endcase
    return c;
  endfunction

  function automatic logic [WidthW-1:0] open_width(input logic [1:0] distance);
    logic [WidthW-1:0] w;
    case (distance)
      2'd2:    w = 5'd4;
      2'd3:    w = 5'd4;
      default: w = 5'd3;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rrc_fifo.sv
// ----------------------------------------------------------------------------
// rrc_fifo
// Small command queue between the classifier and the bit packer.
// ----------------------------------------------------------------------------
module rrc_fifo
  import rrc_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hw/rtl/rrc_front.sv
// ----------------------------------------------------------------------------
// rrc_front
// Item classifier: run detection, byte cache and code command issue.
// ----------------------------------------------------------------------------
module rrc_front
  import rrc_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MaxRowBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       row_end_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_cmd_o
);

  localparam int unsigned CapRaw = (MAX_ROW_BYTES - 1 > 2047) ? 2047 : MAX_ROW_BYTES - 1;
  localparam int unsigned CapVal = (CapRaw < 1) ? 1 : CapRaw;
  localparam logic [10:0] RunCap = 11'(CapVal);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_HEAD  = 4'b0010,
    F_CHUNK = 4'b0100,
    F_FRESH = 4'b1000
  } fstate_e;

  fstate_e     state_q, state_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [7:0]  hist_q [3];
  logic [7:0]  hist_d [3];
  logic [1:0]  rowpos_q, rowpos_d;
  logic        run_act_q, run_act_d;
  logic [1:0]  run_dist_q, run_dist_d;
  logic [10:0] run_len_q, run_len_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  cache_q [16];
  logic [7:0]  cache_d [16];
  logic [3:0]  rp_q, rp_d;

  logic        hit1, hit2, hit3, any_hit;
  logic [1:0]  hit_dist;
  logic [7:0]  inv;
  logic        c_hit;
  logic [3:0]  c_idx;
  cmd_t        fresh_cmd;
  logic        fresh_act;
  logic [7:0]  run_ref;
  logic        run_match;
  logic [10:0] len_inc;
  logic        fin, fin_act;
  logic [1:0]  fin_dist;
  logic [10:0] fin_len;
  logic        cache_wr;

  // Classify the latched byte against row history and cache.
  always_comb begin
    hit1     = (rowpos_q >= 2'd1) && (byte_q == hist_q[0]);
    hit2     = (rowpos_q >= 2'd2) && (byte_q == hist_q[1]);
    hit3     = (rowpos_q == 2'd3) && (byte_q == hist_q[2]);
    any_hit  = hit1 || hit2 || hit3;
    hit_dist = hit1 ? 2'd1 : (hit2 ? 2'd2 : 2'd3);
    inv      = byte_q ^ InvMask;
    c_hit    = 1'b0;
    c_idx    = '0;
    for (int i = 0; i < 16; i++) begin
      if (!c_hit && (cache_q[i] == inv)) begin
        c_hit = 1'b1;
        c_idx = 4'(i);
      end
    end
    fresh_cmd.op  = OP_CODE;
    fresh_cmd.eoi = 1'b1;
    if (any_hit) begin
      if (last_q) begin
        fresh_cmd.code  = CodeW'({open_code(hit_dist)})
                        | (CodeW'(RestCode) << open_width(hit_dist));
        fresh_cmd.width = open_width(hit_dist) + RestWidth;
      end else begin
        fresh_cmd.code  = CodeW'(open_code(hit_dist));
        fresh_cmd.width = open_width(hit_dist);
      end
    end else if (c_hit) begin
      fresh_cmd.code  = CodeW'({c_idx, HitTag});
      fresh_cmd.width = HitWidth;
    end else begin
      fresh_cmd.code  = CodeW'({inv, MissTag});
      fresh_cmd.width = MissWidth;
    end
    fresh_act = any_hit && !last_q;

    case (run_dist_q)
      2'd2:    run_ref = hist_q[1];
      2'd3:    run_ref = hist_q[2];
      default: run_ref = hist_q[0];
    endcase
    run_match = (byte_q == run_ref);
    len_inc   = (run_len_q < RunCap) ? run_len_q + 11'd1 : run_len_q;
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    byte_d     = byte_q;
    last_d     = last_q;
    hist_d     = hist_q;
    rowpos_d   = rowpos_q;
    run_act_d  = run_act_q;
    run_dist_d = run_dist_q;
    run_len_d  = run_len_q;
    rem_d      = rem_q;
    cache_d    = cache_q;
    rp_d       = rp_q;
    in_ready_o = 1'b0;
    push_valid_o = 1'b0;
    push_cmd_o   = '{op: OP_CODE, code: '0, width: '0, eoi: 1'b0};
    fin      = 1'b0;
    fin_act  = 1'b0;
    fin_dist = '0;
    fin_len  = '0;
    cache_wr = 1'b0;

    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = kind_e'(kind_i);
          byte_d  = data_byte_i;
          last_d  = row_end_i;
          state_d = F_HEAD;
        end
      end
      F_HEAD: begin
        case (kind_q)
          KIND_BYTE: begin
            if (run_act_q && run_match) begin
              if (last_q) begin
                push_valid_o = 1'b1;
                push_cmd_o   = '{op: OP_CODE, code: CodeW'(RestCode), width: RestWidth,
                                 eoi: 1'b1};
              end
              if (!last_q || push_ready_i) begin
                fin      = 1'b1;
                fin_act  = 1'b1;
                fin_dist = run_dist_q;
                fin_len  = len_inc;
                state_d  = F_IDLE;
              end
            end else if (run_act_q) begin
              // Close the run: short count, or escape plus chunks.
              push_valid_o = 1'b1;
              if (run_len_q < 11'd8) begin
                push_cmd_o = '{op: OP_CODE, code: CodeW'(cnt_code(run_len_q[2:0])),
                               width: cnt_width(run_len_q[2:0]), eoi: 1'b0};
                if (push_ready_i) state_d = F_FRESH;
              end else begin
                push_cmd_o = '{op: OP_CODE, code: CodeW'(EscCode), width: EscWidth,
                               eoi: 1'b0};
                if (push_ready_i) begin
                  rem_d   = run_len_q;
                  state_d = F_CHUNK;
                end
              end
            end else begin
              push_valid_o = 1'b1;
              push_cmd_o   = fresh_cmd;
              if (push_ready_i) begin
                cache_wr = !any_hit && !c_hit;
                fin      = 1'b1;
                fin_act  = fresh_act;
                fin_dist = hit_dist;
                fin_len  = 11'd1;
                state_d  = F_IDLE;
              end
            end
          end
          KIND_FLUSH: begin
            push_valid_o = 1'b1;
            push_cmd_o   = '{op: OP_FLUSH, code: '0, width: '0, eoi: 1'b1};
            if (push_ready_i) state_d = F_IDLE;
          end
          KIND_STRIPE: begin
            push_valid_o = 1'b1;
            push_cmd_o   = '{op: OP_CLEAR, code: '0, width: '0, eoi: 1'b1};
            if (push_ready_i) begin
              for (int i = 0; i < 3; i++) hist_d[i] = '0;
              for (int i = 0; i < 16; i++) cache_d[i] = 8'(i);
              rowpos_d   = '0;
              run_act_d  = 1'b0;
              run_dist_d = '0;
              run_len_d  = '0;
              rp_d       = '0;
              state_d    = F_IDLE;
            end
          end
          default: begin
            state_d = F_IDLE;
          end
        endcase
      end
      F_CHUNK: begin
        push_valid_o = 1'b1;
        if (rem_q >= 11'(ChunkMax)) begin
          push_cmd_o = '{op: OP_CODE, code: CodeW'(ChunkMax), width: ChunkW, eoi: 1'b0};
          if (push_ready_i) rem_d = rem_q - 11'(ChunkMax);
        end else begin
          push_cmd_o = '{op: OP_CODE, code: CodeW'(rem_q[6:0]), width: ChunkW, eoi: 1'b0};
          if (push_ready_i) state_d = F_FRESH;
        end
      end
      F_FRESH: begin
        push_valid_o = 1'b1;
        push_cmd_o   = fresh_cmd;
        if (push_ready_i) begin
          cache_wr = !any_hit && !c_hit;
          fin      = 1'b1;
          fin_act  = fresh_act;
          fin_dist = hit_dist;
          fin_len  = 11'd1;
          state_d  = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase

    // Replace the round-robin cache slot on a miss.
    if (cache_wr) begin
      cache_d[rp_q] = inv;
      rp_d          = rp_q + 4'd1;
    end

    // Advance row history and run state at the end of a byte.
    if (fin) begin
      if (last_q) begin
        for (int i = 0; i < 3; i++) hist_d[i] = '0;
        rowpos_d   = '0;
        run_act_d  = 1'b0;
        run_dist_d = '0;
        run_len_d  = '0;
      end else begin
        hist_d[2]  = hist_q[1];
        hist_d[1]  = hist_q[0];
        hist_d[0]  = byte_q;
        rowpos_d   = (rowpos_q == 2'd3) ? rowpos_q : rowpos_q + 2'd1;
        run_act_d  = fin_act;
        run_dist_d = fin_act ? fin_dist : '0;
        run_len_d  = fin_act ? fin_len : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      rowpos_q   <= '0;
      run_act_q  <= 1'b0;
      run_dist_q <= '0;
      run_len_q  <= '0;
      rp_q       <= '0;
      for (int i = 0; i < 3; i++) hist_q[i] <= '0;
      for (int i = 0; i < 16; i++) cache_q[i] <= 8'(i);
    end else begin
      state_q    <= state_d;
      rowpos_q   <= rowpos_d;
      run_act_q  <= run_act_d;
      run_dist_q <= run_dist_d;
      run_len_q  <= run_len_d;
      rp_q       <= rp_d;
      hist_q     <= hist_d;
      cache_q    <= cache_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
    rem_q  <= rem_d;
  end

endmodule

>>> hw/rtl/rrc_pack.sv
// ----------------------------------------------------------------------------
// rrc_pack
// Bit packer: merges codes LSB-first into 16-bit words and marks item ends.
// ----------------------------------------------------------------------------
module rrc_pack
  import rrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_word_o,
  output logic        last_word_o
);

  logic [31:0] acc_q, acc_d;
  logic [4:0]  bc_q, bc_d;
  logic [15:0] hold_q, hold_d;
  logic        hold_v_q, hold_v_d;
  logic        hold_last_q, hold_last_d;
  logic [15:0] out_q, out_d;
  logic        out_last_q, out_last_d;
  logic        out_v_q, out_v_d;

  logic [31:0] sum, nacc;
  logic [5:0]  nbc_full;
  logic [4:0]  nbc;
  logic        produced;
  logic [15:0] word;
  logic        out_free, pop;

  always_comb begin
    sum      = acc_q | ({17'b0, cmd_i.code} << bc_q);
    nbc_full = {1'b0, bc_q} + {1'b0, cmd_i.width};
    produced = 1'b0;
    word     = acc_q[15:0];
    nacc     = acc_q;
    nbc      = bc_q;
    case (cmd_i.op)
      OP_CODE: begin
        word = sum[15:0];
        if (nbc_full >= 6'd16) begin
          produced = 1'b1;
          nacc     = sum >> 16;
          nbc      = 5'(nbc_full - 6'd16);
        end else begin
          nacc = sum;
          nbc  = nbc_full[4:0];
        end
      end
      OP_FLUSH: begin
        produced = (bc_q != '0);
        nacc     = '0;
        nbc      = '0;
      end
      OP_CLEAR: begin
        nacc = '0;
        nbc  = '0;
      end
      default: begin
        nacc = acc_q;
        nbc  = bc_q;
      end
    endcase
  end

  assign out_free    = !out_v_q || out_ready_i;
  // Hold back while the held word waits to leave as an item's last word.
  assign pop         = cmd_valid_i && !(hold_v_q && hold_last_q)
                    && !(produced && hold_v_q && !out_free);
  assign cmd_ready_o = pop;

  always_comb begin
    acc_d       = acc_q;
    bc_d        = bc_q;
    hold_d      = hold_q;
    hold_v_d    = hold_v_q;
    hold_last_d = hold_last_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_v_d     = out_v_q && !out_ready_i;
    if (hold_v_q && hold_last_q && out_free) begin
      out_d       = hold_q;
      out_last_d  = 1'b1;
      out_v_d     = 1'b1;
      hold_v_d    = 1'b0;
      hold_last_d = 1'b0;
    end else if (pop) begin
      acc_d = nacc;
      bc_d  = nbc;
      if (produced) begin
        if (hold_v_q) begin
          out_d      = hold_q;
          out_last_d = 1'b0;
          out_v_d    = 1'b1;
        end
        hold_d      = word;
        hold_v_d    = 1'b1;
        hold_last_d = cmd_i.eoi;
      end else if (cmd_i.eoi && hold_v_q) begin
        hold_last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      bc_q        <= '0;
      hold_v_q    <= 1'b0;
      hold_last_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      bc_q        <= bc_d;
      hold_v_q    <= hold_v_d;
      hold_last_q <= hold_last_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign code_word_o = out_q;
  assign last_word_o = out_last_q;

  a_pending_bits_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> bc_q) == 32'd0)
    else $error("accumulator holds bits above the fill count");

  a_hold_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_last_q |-> hold_v_q)
    else $error("item end flagged without a held word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> ($stable(out_q) && $stable(out_last_q)))
    else $error("stalled output word changed");

endmodule

>>> hw/rtl/raster_row_run_cache_compressor.sv
// ----------------------------------------------------------------------------
// raster_row_run_cache_compressor
// Printer raster row compressor: copy-left runs, a 16-entry byte cache and
// an LSB-first 16-bit word packer.
// ----------------------------------------------------------------------------
// A plain raster byte is accepted in F_IDLE and F_HEAD issues its code to
// the command queue. Closing a run by a mismatch issues the count code from
// F_HEAD and the byte's code from F_FRESH; a count above seven instead has
// the escape code, then 7-bit chunks of up to 127 from F_CHUNK. Each state
// that issues waits for the queue to take its command. The packer consumes
// one command per cycle unless an output stall holds it back; an item that
// ends on a held word sends that word out before the next command. The
// queue lets the classifier run ahead of a stalled output. Each item
// yields zero or more words, its last one flagged with last_word_o. Cache
// and history sit in flip-flops, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module raster_row_run_cache_compressor
  import rrc_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = MaxRowBytesDef,
  parameter int unsigned FIFO_DEPTH    = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        row_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_word_o,
  output logic        last_word_o
);

  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // Classify items and issue packer commands.
  rrc_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .row_end_i    (row_end_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Decouple classifier and packer.
  rrc_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Pack codes into words.
  rrc_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_word_o (code_word_o),
    .last_word_o (last_word_o)
  );

endmodule

>>> test/raster_row_run_cache_compressor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raster_row_run_cache_compressor_test
// Drives raster rows, flushes and stripe starts into the compressor and checks
// every packed word against a cycle-free model of runs, cache and packer.
// ----------------------------------------------------------------------------
module raster_row_run_cache_compressor_test;
  import rrc_pkg::*;

  localparam int unsigned RunCap = 2047;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       row_end;
  } raster_item_t;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } packed_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        row_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_word_o;
  logic        last_word_o;

  raster_row_run_cache_compressor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .row_end_i   (row_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_word_o (code_word_o),
    .last_word_o (last_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state of the compressor.
  logic [7:0]  hist [3];
  int unsigned row_pos;
  bit          run_on;
  int unsigned run_dist;
  int unsigned run_len;
  logic [7:0]  cache [16];
  logic [3:0]  repl_ptr;
  logic [31:0] acc;
  int unsigned acc_bits;

  raster_item_t pending_items[$];
  packed_word_t expected_words[$];
  packed_word_t item_words[$];

  int  mismatches = 0;
  int  words_checked = 0;
  int  items_sent = 0;
  bit  quiet_tail = 1'b0;
  bit  long_stall = 1'b0;
  bit  in_fire = 1'b0;

  function automatic void clear_model();
    for (int i = 0; i < 3; i++) hist[i] = '0;
    row_pos = 0; run_on = 0; run_dist = 0; run_len = 0;
    for (int i = 0; i < 16; i++) cache[i] = 8'(i);
    repl_ptr = '0; acc = '0; acc_bits = 0;
  endfunction

  function automatic void pack_bits(logic [31:0] code, int unsigned width);
    packed_word_t w;
    acc |= (code & 32'hffff) << (acc_bits & 15);
    acc_bits += width;
    if (acc_bits >= 16) begin
      w.word = acc[15:0];
      w.last = 1'b0;
      item_words.push_back(w);
      acc = acc >> 16;
      acc_bits -= 16;
    end
  endfunction

  function automatic void pack_count(int unsigned len);
    logic [5:0] c;
    int unsigned wd;
    if (len < 8) begin
      case (len)
        2: begin c = 6'h01; wd = 2; end
        3: begin c = 6'h03; wd = 4; end
        4: begin c = 6'h0b; wd = 4; end
        5: begin c = 6'h0f; wd = 5; end
        6: begin c = 6'h1f; wd = 6; end
        7: begin c = 6'h3f; wd = 6; end
        default: begin c = 6'h00; wd = 1; end
      endcase
      pack_bits(32'(c), wd);
      return;
    end
    pack_bits(32'h7, 4);
    while (len >= 127) begin
      pack_bits(32'd127, 7);
      len -= 127;
    end
    pack_bits(32'(len), 7);
  endfunction

  function automatic void code_fresh_byte(logic [7:0] b, bit last);
    logic [7:0] inv;
    for (int d = 1; d <= 3; d++) begin
      if (row_pos >= d && b == hist[d-1]) begin
        case (d)
          1: pack_bits(32'h3, 3);
          2: pack_bits(32'h7, 4);
          default: pack_bits(32'hf, 4);
        endcase
        run_on = 1; run_dist = d; run_len = 1;
        if (last) begin
          pack_bits(32'h007, 11);
          run_on = 0;
        end
        return;
      end
    end
    inv = b ^ 8'hff;
    for (int i = 0; i < 16; i++) begin
      if (cache[i] == inv) begin
        pack_bits(32'h0, 2);
        pack_bits(32'(i), 4);
        return;
      end
    end
    pack_bits(32'h2, 2);
    pack_bits(32'(inv), 8);
    cache[repl_ptr] = inv;
    repl_ptr++;
  endfunction

  // Work out the words one item produces and queue them as expected.
  function automatic void compress_item(raster_item_t it);
    bit done;
    item_words.delete();
    case (it.kind)
      KIND_BYTE: begin
        done = 0;
        if (run_on) begin
          if (it.data == hist[run_dist-1]) begin
            if (run_len < RunCap) run_len++;
            if (it.row_end) begin
              pack_bits(32'h007, 11);
              run_on = 0;
            end
            done = 1;
          end else begin
            pack_count(run_len);
            run_on = 0;
          end
        end
        if (!done) code_fresh_byte(it.data, it.row_end);
        hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = it.data;
        if (row_pos < 3) row_pos++;
        if (it.row_end) begin
          for (int i = 0; i < 3; i++) hist[i] = '0;
          row_pos = 0; run_on = 0;
        end
        if (!run_on) begin
          run_dist = 0; run_len = 0;
        end
      end
      KIND_FLUSH: if (acc_bits > 0) pack_bits(32'h0, 16 - acc_bits);
      KIND_STRIPE: clear_model();
      default: ;
    endcase
    if (item_words.size() > 0) item_words[item_words.size()-1].last = 1'b1;
    foreach (item_words[i]) expected_words.push_back(item_words[i]);
  endfunction

  // Note input acceptance at the rising edge.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: present queued items at the falling edge, idle in random bursts.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        compress_item(raster_item_t'({kind_i, data_byte_i, row_end_i}));
        items_sent++;
      end
      if (!in_valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          raster_item_t it;
          it = pending_items.pop_front();
          kind_i      <= it.kind;
          data_byte_i <= it.data;
          row_end_i   <= it.row_end;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stall bursts, or a counted long hold-off.
  int recv_gap = 0;
  int stall_cycles = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_stall) begin
      out_ready_i <= 1'b0;
      stall_cycles++;
      if (stall_cycles >= 300) begin
        stall_cycles = 0;
        long_stall   = 1'b0;
      end
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      packed_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h last %b", code_word_o, last_word_o);
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (exp_w.word !== code_word_o || exp_w.last !== last_word_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %h/%b got %h/%b", words_checked,
                     exp_w.word, exp_w.last, code_word_o, last_word_o);
        end
      end
    end
  end

  function automatic raster_item_t make_byte(logic [7:0] b, bit re);
    raster_item_t it;
    it.kind = KIND_BYTE; it.data = b; it.row_end = re;
    return it;
  endfunction

  function automatic raster_item_t make_ctl(kind_e k);
    raster_item_t it;
    it.kind = k; it.data = 8'($urandom); it.row_end = 1'($urandom);
    return it;
  endfunction

  // Queue one row built from runs, repeats and literals.
  function automatic void queue_row(int unsigned len);
    logic [7:0] row [$];
    logic [7:0] b;
    int unsigned sel;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 9);
      if (i > 0 && sel < 4) b = row[i-1];
      else if (i > 1 && sel < 6) b = row[i-$urandom_range(1, (i > 2) ? 3 : 2)];
      else if (sel < 8) b = 8'($urandom_range(0, 20)) ^ 8'hff;
      else b = 8'($urandom);
      row.push_back(b);
      pending_items.push_back(make_byte(b, i == len - 1));
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    clear_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: literals, cache hits, runs of each distance, closes, flushes.
    pending_items.push_back(make_byte(8'hff, 0));   // cache hit on entry 0
    pending_items.push_back(make_byte(8'h00, 0));   // miss, literal
    pending_items.push_back(make_byte(8'h00, 0));   // distance-1 run
    pending_items.push_back(make_byte(8'h00, 0));
    pending_items.push_back(make_byte(8'h5a, 0));   // close by mismatch
    pending_items.push_back(make_byte(8'ha5, 0));
    pending_items.push_back(make_byte(8'h5a, 0));   // distance-2 run
    pending_items.push_back(make_byte(8'h11, 0));
    pending_items.push_back(make_byte(8'h22, 0));
    pending_items.push_back(make_byte(8'h5a, 1));   // distance-3, rest at row end
    pending_items.push_back(make_ctl(KIND_FLUSH));
    pending_items.push_back(make_ctl(KIND_FLUSH));  // nothing pending
    pending_items.push_back(make_ctl(KIND_RSVD));   // ignored
    pending_items.push_back(make_byte(8'h80, 0));
    pending_items.push_back(make_ctl(KIND_STRIPE));
    pending_items.push_back(make_byte(8'h7f, 1));   // single-byte row
    for (int i = 0; i < 300; i++)                  // long run, chunked count
      pending_items.push_back(make_byte(8'h33, 0));
    pending_items.push_back(make_byte(8'hcc, 1));
    pending_items.push_back(make_ctl(KIND_FLUSH));
    wait_drained();

    // Receiver holds off while the sender keeps offering.
    for (int r = 0; r < 4; r++) queue_row($urandom_range(4, 12));
    @(negedge clk_i) long_stall = 1'b1;
    wait (!long_stall);
    wait_drained();

    // Random rows with scattered control items.
    while (items_sent < 440) begin
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) pending_items.push_back(make_ctl(KIND_STRIPE));
      else if (pick < 3) pending_items.push_back(make_ctl(KIND_FLUSH));
      else if (pick == 3) pending_items.push_back(make_ctl(KIND_RSVD));
      else if (pick == 4) queue_row($urandom_range(20, 40));
      else queue_row($urandom_range(1, 10));
      if (items_sent > 380) quiet_tail = 1'b1;
      while (pending_items.size() > 0) @(posedge clk_i);
    end
    pending_items.push_back(make_ctl(KIND_FLUSH));
    wait_drained();

    $display("covered %0d items and %0d words: literals, cache hits, runs,",
             items_sent, words_checked);
    $display("long counts, flushes, stripe starts and a long output stall");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> raster_row_run_cache_compressor.f
hw/rtl/rrc_pkg.sv
hw/rtl/rrc_fifo.sv
hw/rtl/rrc_front.sv
hw/rtl/rrc_pack.sv
hw/rtl/raster_row_run_cache_compressor.sv
test/raster_row_run_cache_compressor_test.sv
